// ===== rtl/turn_tcp_message_deframer_assert.svh =====
// ----------------------------------------------------------------------------
// turn_tcp_message_deframer assertion macros
// shared assertion forms for the deframer checker
// ----------------------------------------------------------------------------
`ifndef TURN_TCP_MESSAGE_DEFRAMER_ASSERT_SVH
`define TURN_TCP_MESSAGE_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TMD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, disabled while reset is asserted
`define TMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ===== rtl/tmd_pkg.sv =====
// ----------------------------------------------------------------------------
// tmd_pkg
// types and constants shared by the TURN over TCP message deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmd_pkg;

    // first-byte bit that selects channel data framing
    localparam int CHANNEL_BIT = 6;

    // header sizes in bytes
    localparam logic [4:0] STUN_HDR_LEN = 5'd20;
    localparam logic [4:0] CHAN_HDR_LEN = 5'd4;

    // header byte positions of the big-endian length field
    localparam logic [4:0] LEN_HI_POS = 5'd2;
    localparam logic [4:0] LEN_LO_POS = 5'd3;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // tuser bit positions
    localparam int TUSER_FIRST = 0;
    localparam int TUSER_CHAN  = 1;
    localparam int TUSER_HDR   = 2;
    localparam int TUSER_W     = 3;

    // one classified stream byte
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       chan;
        logic       hdr;
    } beat_t;

endpackage

// ===== rtl/tmd_front.sv =====
// ----------------------------------------------------------------------------
// tmd_front
// accepts stream bytes, tracks header and body and tags each beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmd_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          channel_mode,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    output logic          push,
    output tmd_pkg::beat_t push_beat,
    input  logic          queue_full
);
    import tmd_pkg::*;

    logic        in_body_reg, in_body_next;
    logic [4:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [15:0] len_hold_reg, len_hold_next;
    logic [16:0] left_reg, left_next;
    logic        chan_reg, chan_next;

    logic        fire;
    logic        start;
    logic        chan_cur;
    logic [15:0] len_base;
    logic [15:0] len_cur;
    logic [4:0]  hsize;
    logic        hdr_end;
    logic [16:0] len_round;
    logic        body_end;

    assign in_ready = !queue_full;
    assign fire     = in_valid && !queue_full;
    assign push     = fire;

    // classification of the current byte
    always_comb begin
        start    = !in_body_reg && (hdr_cnt_reg == 5'd0);
        chan_cur = start ? (channel_mode & in_byte[CHANNEL_BIT]) : chan_reg;
        len_base = start ? 16'd0 : len_hold_reg;
        len_cur  = len_base;
        if (hdr_cnt_reg == LEN_HI_POS) begin
            len_cur = {in_byte, len_base[7:0]};
        end else if (hdr_cnt_reg == LEN_LO_POS) begin
            len_cur = {len_base[15:8], in_byte};
        end
        hsize     = chan_cur ? CHAN_HDR_LEN : STUN_HDR_LEN;
        hdr_end   = ({1'b0, hdr_cnt_reg} + 6'd1) >= {1'b0, hsize};
        len_round = chan_cur ? (({1'b0, len_cur} + 17'd3) & ~17'd3) : {1'b0, len_cur};
        body_end  = (left_reg <= 17'd1);

        in_body_next  = in_body_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        len_hold_next = len_hold_reg;
        left_next     = left_reg;
        chan_next     = chan_reg;

        push_beat.data  = in_byte;
        push_beat.first = start;
        push_beat.last  = 1'b0;
        push_beat.chan  = chan_cur;
        push_beat.hdr   = !in_body_reg;

        if (!in_body_reg) begin
            chan_next     = chan_cur;
            len_hold_next = len_cur;
            if (hdr_end) begin
                hdr_cnt_next = 5'd0;
                if (len_round == 17'd0) begin
                    push_beat.last = 1'b1;
                    left_next      = 17'd0;
                end else begin
                    in_body_next = 1'b1;
                    left_next    = len_round;
                end
            end else begin
                hdr_cnt_next = hdr_cnt_reg + 5'd1;
            end
        end else begin
            if (left_reg != 17'd0) begin
                left_next = left_reg - 17'd1;
            end
            if (body_end) begin
                push_beat.last = 1'b1;
                in_body_next   = 1'b0;
                hdr_cnt_next   = 5'd0;
            end
        end
    end

    // framing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_body_reg  <= 1'b0;
            hdr_cnt_reg  <= 5'd0;
            len_hold_reg <= 16'd0;
            left_reg     <= 17'd0;
            chan_reg     <= 1'b0;
        end else if (fire) begin
            in_body_reg  <= in_body_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            len_hold_reg <= len_hold_next;
            left_reg     <= left_next;
            chan_reg     <= chan_next;
        end
    end

endmodule

// ===== rtl/tmd_queue.sv =====
// ----------------------------------------------------------------------------
// tmd_queue
// short first-in first-out queue of tagged beats between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmd_queue #(
    parameter int DEPTH = tmd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tmd_pkg::beat_t push_beat,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output tmd_pkg::beat_t pop_beat
);
    import tmd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    beat_t           slots_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_beat  = slots_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_beat;
        end
    end

endmodule

// ===== rtl/tmd_back.sv =====
// ----------------------------------------------------------------------------
// tmd_back
// output register: drains the queue and presents beats on the master side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmd_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_not_empty,
    input  tmd_pkg::beat_t            q_beat,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,
    output logic                      m_tlast,
    output logic [tmd_pkg::TUSER_W-1:0] m_tuser
);
    import tmd_pkg::*;

    logic  valid_reg;
    beat_t beat_reg;

    // load when the register is empty or its beat leaves this cycle
    assign q_pop = q_not_empty && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            beat_reg <= q_beat;
        end
    end

    // pack the flags onto the bus
    always_comb begin
        m_tvalid             = valid_reg;
        m_tdata              = beat_reg.data;
        m_tlast              = beat_reg.last;
        m_tuser              = '0;
        m_tuser[TUSER_FIRST] = beat_reg.first;
        m_tuser[TUSER_CHAN]  = beat_reg.chan;
        m_tuser[TUSER_HDR]   = beat_reg.hdr;
    end

endmodule

// ===== rtl/turn_tcp_message_deframer.sv =====
// ----------------------------------------------------------------------------
// turn_tcp_message_deframer
// marks STUN and ChannelData message boundaries in a TURN over TCP byte stream
// ----------------------------------------------------------------------------
// Takes one stream byte per beat and passes it on unchanged, one beat per
// clock cycle sustained while the output side keeps m_tready high. The
// front end classifies each byte as it is accepted (a 20-byte STUN header, or
// a 4-byte ChannelData header when channel_mode is set and bit 6 of the first
// byte is set) and counts the body down from the length field, rounded up to
// four bytes for ChannelData. A short queue and an output register follow, so
// input keeps flowing while an output beat waits. channel_mode is sampled on
// the first byte of each message; write it only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module turn_tcp_message_deframer #(
    parameter int QUEUE_DEPTH = tmd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration write: bit 0 channel_mode
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data,
    // tdata: [7:0] stream_byte
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    // tdata: [7:0] out_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,
    output logic                        m_tlast,
    // tuser: [0] msg_first, [1] is_channel, [2] in_header
    output logic [tmd_pkg::TUSER_W-1:0] m_tuser
);
    import tmd_pkg::*;

    logic  mode_reg;
    logic  push, q_full, q_pop, q_not_empty;
    beat_t push_beat, q_beat;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    tmd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .channel_mode (mode_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_byte      (s_tdata),
        .push         (push),
        .push_beat    (push_beat),
        .queue_full   (q_full)
    );

    tmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_beat (push_beat),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_beat  (q_beat)
    );

    tmd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_beat      (q_beat),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== rtl/tmd_checker.sv =====
// ----------------------------------------------------------------------------
// tmd_checker
// port-level checks of message marking on the deframer output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "turn_tcp_message_deframer_assert.svh"

module tmd_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [7:0]                  m_tdata,
    input logic                        m_tlast,
    input logic [tmd_pkg::TUSER_W-1:0] m_tuser
);
    import tmd_pkg::*;

    logic out_beat;
    logic expect_first_reg;
    logic chan_reg;

    assign out_beat = m_tvalid && m_tready;

    // track message position and kind as seen on the output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_first_reg <= 1'b1;
            chan_reg         <= 1'b0;
        end else if (out_beat) begin
            expect_first_reg <= m_tlast;
            chan_reg         <= m_tuser[TUSER_CHAN];
        end
    end

    // stalled beat holds
    `TMD_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // a message start is always a header byte
    `TMD_ASSERT_IMPLY(a_first_hdr, aclk, aresetn, m_tvalid && m_tuser[TUSER_FIRST], m_tuser[TUSER_HDR])

    // a message starts exactly after the previous one ended
    `TMD_ASSERT_IMPLY(a_first_seq, aclk, aresetn, out_beat, m_tuser[TUSER_FIRST] == expect_first_reg)

    // message kind stays fixed within a message
    `TMD_ASSERT_IMPLY(a_chan_fixed, aclk, aresetn, out_beat && !expect_first_reg, m_tuser[TUSER_CHAN] == chan_reg)

endmodule

bind turn_tcp_message_deframer tmd_checker u_tmd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== test/turn_tcp_message_deframer_checker.sv =====
// ----------------------------------------------------------------------------
// turn_tcp_message_deframer_checker
// predicts and checks the classified byte stream of the message deframer
// ----------------------------------------------------------------------------
// Watches the configuration channel, the input stream and the output stream.
// Every accepted input byte is run through a byte-serial framing model that
// keeps its own header position, length field, body count and message kind,
// and the expected output beat is queued. Every accepted output beat is
// compared field by field with the oldest queued beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module turn_tcp_message_deframer_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic                        cfg_data,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    // tdata: [7:0] stream_byte
    input  logic [7:0]                  s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    // tdata: [7:0] out_byte
    input  logic [7:0]                  m_tdata,
    input  logic                        m_tlast,
    // tuser: [0] msg_first, [1] is_channel, [2] in_header
    input  logic [tmd_pkg::TUSER_W-1:0] m_tuser,
    output int unsigned                 fail_count,
    output int unsigned                 pending,
    output int unsigned                 beat_count,
    output int unsigned                 msg_count,
    output int unsigned                 chan_msg_count
);

    localparam int unsigned MAX_REPORTS = 20;

    // framing state of the stream
    logic        chan_mode;
    logic        in_body;
    logic [4:0]  hdr_pos;
    logic [15:0] len_field;
    logic [16:0] body_left;
    logic        msg_chan;

    tmd_pkg::beat_t expected_beats[$];
    tmd_pkg::beat_t got_beat;
    tmd_pkg::beat_t want_beat;

    // classify one stream byte and queue the beat it must leave as
    task automatic frame_byte(input logic [7:0] b);
        tmd_pkg::beat_t bt;
        logic [4:0]     hdr_len;
        logic [16:0]    body_len;
        bt      = '0;
        bt.data = b;
        if (!in_body) begin
            bt.hdr = 1'b1;
            // first byte picks the message kind
            if (hdr_pos == 5'd0) begin
                bt.first  = 1'b1;
                msg_chan  = chan_mode & b[tmd_pkg::CHANNEL_BIT];
                len_field = '0;
            end
            // big-endian length field
            if (hdr_pos == tmd_pkg::LEN_HI_POS) begin
                len_field[15:8] = b;
            end else if (hdr_pos == tmd_pkg::LEN_LO_POS) begin
                len_field[7:0] = b;
            end
            hdr_len = msg_chan ? tmd_pkg::CHAN_HDR_LEN : tmd_pkg::STUN_HDR_LEN;
            if (hdr_pos + 5'd1 >= hdr_len) begin
                // channel data bodies are padded to four bytes
                body_len = msg_chan ? (({1'b0, len_field} + 17'd3) & ~17'd3)
                                    : {1'b0, len_field};
                hdr_pos = '0;
                if (body_len == '0) begin
                    bt.last   = 1'b1;
                    body_left = '0;
                end else begin
                    in_body   = 1'b1;
                    body_left = body_len;
                end
            end else begin
                hdr_pos = hdr_pos + 5'd1;
            end
        end else begin
            // body countdown
            if (body_left != '0) begin
                body_left = body_left - 17'd1;
            end
            if (body_left == '0) begin
                bt.last = 1'b1;
                in_body = 1'b0;
                hdr_pos = '0;
            end
        end
        bt.chan = msg_chan;
        expected_beats.insert(expected_beats.size(), bt);
    endtask

    // sample all channels at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            chan_mode      = 1'b0;
            in_body        = 1'b0;
            hdr_pos        = '0;
            len_field      = '0;
            body_left      = '0;
            msg_chan       = 1'b0;
            fail_count     = 0;
            beat_count     = 0;
            msg_count      = 0;
            chan_msg_count = 0;
            expected_beats.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                chan_mode = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                frame_byte(s_tdata);
            end
            // output beat against the oldest expectation
            if (m_tvalid && m_tready) begin
                got_beat.data  = m_tdata;
                got_beat.first = m_tuser[tmd_pkg::TUSER_FIRST];
                got_beat.last  = m_tlast;
                got_beat.chan  = m_tuser[tmd_pkg::TUSER_CHAN];
                got_beat.hdr   = m_tuser[tmd_pkg::TUSER_HDR];
                if (expected_beats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected output beat data=%02h first=%b last=%b",
                                 $time, got_beat.data, got_beat.first, got_beat.last);
                    end
                end else begin
                    want_beat = expected_beats[0];
                    expected_beats.delete(0);
                    if (got_beat !== want_beat) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: beat %0d expected data=%02h first=%b last=%b chan=%b hdr=%b",
                                     $time, beat_count, want_beat.data, want_beat.first,
                                     want_beat.last, want_beat.chan, want_beat.hdr);
                            $display("%0t: beat %0d actual   data=%02h first=%b last=%b chan=%b hdr=%b",
                                     $time, beat_count, got_beat.data, got_beat.first,
                                     got_beat.last, got_beat.chan, got_beat.hdr);
                        end
                    end
                end
                beat_count++;
                if (got_beat.last) begin
                    msg_count++;
                    if (got_beat.chan) begin
                        chan_msg_count++;
                    end
                end
            end
        end
        pending = expected_beats.size();
    end

endmodule

// ===== test/turn_tcp_message_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// turn_tcp_message_deframer_tb
// stimulus and verdict for the TURN over TCP message deframer
// ----------------------------------------------------------------------------
// Streams STUN and ChannelData messages with random content through the
// deframer: empty bodies, padded channel bodies, and mode changes in the
// middle of a header, then about 1100 random bytes of mixed messages, some
// 1600 bytes in all. Both sides idle at random; the receiver also holds off
// for a long stretch while the sender keeps pushing. A checker module
// predicts and compares every output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module turn_tcp_message_deframer_tb;

    localparam int unsigned RAND_BYTES     = 1100;
    localparam int unsigned RX_HOLD_CYCLES = 100;
    localparam int unsigned SETTLE_CYCLES  = 4;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic                        cfg_data;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [7:0]                  s_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [7:0]                  m_tdata;
    logic                        m_tlast;
    logic [tmd_pkg::TUSER_W-1:0] m_tuser;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned beat_count;
    int unsigned msg_count;
    int unsigned chan_msg_count;

    // stimulus control shared by sender and receiver
    logic        cur_mode;
    logic        tx_burst;
    logic        rx_steady;
    logic        rx_hold;
    int unsigned bytes_sent;
    int unsigned mode_writes;

    turn_tcp_message_deframer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    turn_tcp_message_deframer_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .fail_count     (fail_count),
        .pending        (pending),
        .beat_count     (beat_count),
        .msg_count      (msg_count),
        .chan_msg_count (chan_msg_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("turn_tcp_message_deframer_tb failed");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // offer one byte, entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = tx_burst ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    // stop offering and wait until every beat has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // write channel_mode while the block is idle
    task automatic set_mode(input logic v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_mode = v;
        mode_writes++;
    endtask

    // one whole message; flip_at >= 0 toggles the mode before that byte
    task automatic put_msg(input logic [7:0] first_b, input logic [15:0] len,
                           input int flip_at);
        logic       chan;
        int         total;
        int         n;
        logic [7:0] b;
        chan  = cur_mode & first_b[tmd_pkg::CHANNEL_BIT];
        total = chan ? int'(tmd_pkg::CHAN_HDR_LEN) + ((int'(len) + 3) & ~3)
                     : int'(tmd_pkg::STUN_HDR_LEN) + int'(len);
        for (n = 0; n < total; n++) begin
            if (n == flip_at) begin
                set_mode(!cur_mode);
            end
            if (n == 0) begin
                b = first_b;
            end else if (n == int'(tmd_pkg::LEN_HI_POS)) begin
                b = len[15:8];
            end else if (n == int'(tmd_pkg::LEN_LO_POS)) begin
                b = len[7:0];
            end else begin
                b = 8'($urandom);
            end
            send_byte(b);
        end
    endtask

    // receiver: random stalls, steady stretches and one long hold-off
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
                rx_hold = 1'b0;
            end else if (rx_steady) begin
                m_tready <= 1'b1;
            end else begin
                stall = pick_gap();
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        int unsigned rand_start;
        int unsigned rand_msgs;
        int unsigned r;
        logic [15:0] len;
        int          flip;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cur_mode    = 1'b0;
        tx_burst    = 1'b0;
        rx_steady   = 1'b0;
        rx_hold     = 1'b0;
        bytes_sent  = 0;
        mode_writes = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // mode off after reset: bit 6 is ignored
        put_msg(8'h00, 16'd0, -1);
        put_msg(8'h40, 16'd4, -1);
        put_msg(8'hFF, 16'd1, -1);
        // mode turned on inside a STUN header, message stays STUN
        put_msg(8'h7F, 16'd3, 5);
        // channel data: empty, padded and aligned bodies
        put_msg(8'h40, 16'd0, -1);
        put_msg(8'h7F, 16'd1, -1);
        put_msg(8'hC0, 16'd5, -1);
        put_msg(8'hFF, 16'd4, -1);
        // STUN with the mode on
        put_msg(8'h00, 16'd2, -1);
        put_msg(8'hBF, 16'd0, -1);
        // mode turned off before the length, message stays channel data
        put_msg(8'h41, 16'd6, 2);
        set_mode(1'b1);
        // a longer padded body, streamed without idling
        tx_burst  = 1'b1;
        rx_steady = 1'b1;
        put_msg(8'h40, 16'd253, -1);
        tx_burst  = 1'b0;
        rx_steady = 1'b0;
        put_msg(8'h00, 16'd100, 0);

        // random mix of messages
        rand_start = bytes_sent;
        rand_msgs  = 0;
        while (bytes_sent - rand_start < RAND_BYTES) begin
            if ($urandom_range(0, 29) == 0) begin
                set_mode(1'($urandom_range(0, 1)));
            end
            if (rand_msgs == 15) begin
                // receiver holds off while the sender keeps pushing
                rx_hold  = 1'b1;
                tx_burst = 1'b1;
                put_msg(8'h01, 16'd48, -1);
                tx_burst = 1'b0;
            end else begin
                if (rand_msgs == 20) begin
                    drain();
                end
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    len = 16'($urandom_range(0, 8));
                end else if (r < 92) begin
                    len = 16'($urandom_range(9, 40));
                end else if (r < 99) begin
                    len = 16'($urandom_range(41, 200));
                end else begin
                    len = 16'($urandom_range(256, 700));
                end
                flip = ($urandom_range(0, 24) == 0) ? int'($urandom_range(1, 3)) : -1;
                put_msg(8'($urandom), len, flip);
            end
            rand_msgs++;
        end

        drain();
        $display("run covered %0d output beats in %0d messages, %0d of them channel data",
                 beat_count, msg_count, chan_msg_count);
        $display("channel_mode written %0d times, incl. mid-header changes and a long stall",
                 mode_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("turn_tcp_message_deframer_tb passed");
        end else begin
            $display("turn_tcp_message_deframer_tb failed");
        end
        $finish;
    end

endmodule
